[sv/isotp_pkg.sv]
package isotp_pkg;

    // frame and message geometry
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 12;
    localparam int unsigned MAX_BYTES = 7;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned BUF_W     = MAX_BYTES * BYTE_W;

    // frame type codes, high nibble of byte 0
    localparam logic [3:0] TYPE_SINGLE = 4'h0;
    localparam logic [3:0] TYPE_FIRST  = 4'h1;
    localparam logic [3:0] TYPE_CONSEC = 4'h2;

    // result kind codes
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_FC   = 1'b1;

    // answer of the shared length unit
    typedef struct packed {
        logic [LEN_W-1:0] nxt;   // count after one more byte
        logic             hit;   // that byte completes the message
        logic             zero;  // no byte received yet
    } t_cnt_res;

endpackage

[sv/isotp_frame_if.sv]
interface isotp_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;

    modport source (
        output valid, byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
        input  ready
    );
    modport sink (
        input  valid, byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
        output ready
    );
endinterface

[sv/isotp_result_if.sv]
interface isotp_result_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic       first_of_message;
    logic       last_of_message;
    logic       last_of_run;

    modport source (
        output valid, kind, data_byte, first_of_message, last_of_message, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, kind, data_byte, first_of_message, last_of_message, last_of_run,
        output ready
    );
endinterface

[sv/isotp_len_unit.sv]
// shared length unit: one increment and two compares per emitted byte
module isotp_len_unit (
    input  logic [isotp_pkg::LEN_W-1:0] i_cnt,
    input  logic [isotp_pkg::LEN_W-1:0] i_exp,
    output isotp_pkg::t_cnt_res         o_res
);

    logic [isotp_pkg::LEN_W-1:0] w_inc;

    // next count and completion check
    assign w_inc      = isotp_pkg::LEN_W'(i_cnt + isotp_pkg::LEN_W'(1));
    assign o_res.nxt  = w_inc;
    assign o_res.hit  = (w_inc == i_exp);
    assign o_res.zero = (i_cnt == '0);

endmodule

[sv/isotp_receive_reassembler_unit.sv]
// receive reassembler for segmented diagnostic messages over 8-byte CAN payloads
// channels: i_frame takes one CAN payload (byte0..byte7) per transfer; o_result
//   gives one result per transfer: a message byte, or a request to send the
//   flow-control frame after a first frame
// a frame is decoded into the shift buffer on its transfer, and its results are then
//   loaded into the output register, one per cycle while the output register is free;
//   a frame holds the block until its last result is loaded; the bytes leave one at a
//   time through a shift buffer, and the message count is advanced by one shared
//   increment/compare unit
// ready on i_frame is high only while the sequencer is idle; a frame that
//   causes no result is taken and dropped in its transfer cycle
// a frame may be taken while the final result of the previous one still sits
//   in the output register
// reset: no reception in progress, counts cleared, no result pending
// stall: when the receiver holds ready low the output register keeps its
//   result and the sequencer waits, holding i_frame off
module isotp_receive_reassembler_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    isotp_frame_if.sink     i_frame,
    isotp_result_if.source  o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_FC
    } t_state;

    t_state                        r_state,     n_state;
    logic [isotp_pkg::BUF_W-1:0]   r_bytes,     n_bytes;
    logic [isotp_pkg::IDX_W-1:0]   r_idx,       n_idx;
    logic [isotp_pkg::IDX_W-1:0]   r_avail,     n_avail;
    logic                          r_single,    n_single;
    logic                          r_ff,        n_ff;
    logic                          r_receiving, n_receiving;
    logic [isotp_pkg::LEN_W-1:0]   r_exp,       n_exp;
    logic [isotp_pkg::LEN_W-1:0]   r_cnt,       n_cnt;
    logic                          r_out_valid, n_out_valid;
    logic                          r_kind,      n_kind;
    logic [isotp_pkg::BYTE_W-1:0]  r_data,      n_data;
    logic                          r_first,     n_first;
    logic                          r_lastm,     n_lastm;
    logic                          r_lastr,     n_lastr;

    isotp_pkg::t_cnt_res           w_len;
    logic                          w_out_free;
    logic                          w_idx_end;
    logic [3:0]                    w_type;
    logic [3:0]                    w_nib;
    logic [isotp_pkg::LEN_W-1:0]   w_ff_len;

    isotp_len_unit u_len (
        .i_cnt (r_cnt),
        .i_exp (r_exp),
        .o_res (w_len)
    );

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_idx_end  = (isotp_pkg::IDX_W'(r_idx + isotp_pkg::IDX_W'(1)) == r_avail);
    assign w_type     = i_frame.byte0[7:4];
    assign w_nib      = i_frame.byte0[3:0];
    assign w_ff_len   = {w_nib, i_frame.byte1};

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_bytes     = r_bytes;
        n_idx       = r_idx;
        n_avail     = r_avail;
        n_single    = r_single;
        n_ff        = r_ff;
        n_receiving = r_receiving;
        n_exp       = r_exp;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_data      = r_data;
        n_first     = r_first;
        n_lastm     = r_lastm;
        n_lastr     = r_lastr;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // decode a frame on its transfer
                if (i_frame.valid) begin
                    n_idx = '0;
                    priority if (w_type == isotp_pkg::TYPE_SINGLE) begin
                        if (w_nib != 4'd0 && w_nib <= 4'(isotp_pkg::MAX_BYTES)) begin
                            n_bytes  = {i_frame.byte7, i_frame.byte6, i_frame.byte5,
                                        i_frame.byte4, i_frame.byte3, i_frame.byte2,
                                        i_frame.byte1};
                            n_avail  = w_nib[isotp_pkg::IDX_W-1:0];
                            n_single = 1'b1;
                            n_ff     = 1'b0;
                            n_state  = S_EMIT;
                        end
                    end else if (w_type == isotp_pkg::TYPE_FIRST) begin
                        n_bytes  = {8'h00, i_frame.byte7, i_frame.byte6, i_frame.byte5,
                                    i_frame.byte4, i_frame.byte3, i_frame.byte2};
                        n_avail  = isotp_pkg::IDX_W'(6);
                        n_single = 1'b0;
                        n_ff     = 1'b1;
                        n_exp    = w_ff_len;
                        n_cnt    = '0;
                        if (w_ff_len == '0) begin
                            n_receiving = 1'b0;
                            n_state     = S_FC;
                        end else begin
                            n_receiving = 1'b1;
                            n_state     = S_EMIT;
                        end
                    end else if (w_type == isotp_pkg::TYPE_CONSEC) begin
                        if (r_receiving) begin
                            n_bytes  = {i_frame.byte7, i_frame.byte6, i_frame.byte5,
                                        i_frame.byte4, i_frame.byte3, i_frame.byte2,
                                        i_frame.byte1};
                            n_avail  = isotp_pkg::IDX_W'(isotp_pkg::MAX_BYTES);
                            n_single = 1'b0;
                            n_ff     = 1'b0;
                            n_state  = S_EMIT;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_EMIT: begin
                // one message byte per cycle into the output register while it is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = isotp_pkg::KIND_DATA;
                    n_data      = r_bytes[isotp_pkg::BYTE_W-1:0];
                    n_bytes     = {8'h00, r_bytes[isotp_pkg::BUF_W-1:isotp_pkg::BYTE_W]};
                    n_idx       = isotp_pkg::IDX_W'(r_idx + isotp_pkg::IDX_W'(1));
                    if (r_single) begin
                        n_first = (r_idx == '0);
                        n_lastm = w_idx_end;
                        n_lastr = w_idx_end;
                        if (w_idx_end) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_first = w_len.zero;
                        n_lastm = w_len.hit;
                        n_lastr = (w_len.hit || w_idx_end) && !r_ff;
                        if (w_len.hit) begin
                            n_cnt       = '0;
                            n_receiving = 1'b0;
                        end else begin
                            n_cnt = w_len.nxt;
                        end
                        if (w_len.hit || w_idx_end) begin
                            n_state = r_ff ? S_FC : S_IDLE;
                        end
                    end
                end
            end

            S_FC: begin
                // flow-control request closes a first frame
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = isotp_pkg::KIND_FC;
                    n_data      = '0;
                    n_first     = 1'b0;
                    n_lastm     = 1'b0;
                    n_lastr     = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_receiving <= 1'b0;
            r_exp       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_receiving <= n_receiving;
            r_exp       <= n_exp;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_bytes     <= n_bytes;
            r_idx       <= n_idx;
            r_avail     <= n_avail;
            r_single    <= n_single;
            r_ff        <= n_ff;
            r_kind      <= n_kind;
            r_data      <= n_data;
            r_first     <= n_first;
            r_lastm     <= n_lastm;
            r_lastr     <= n_lastr;
        end
    end

    assign i_frame.ready             = (r_state == S_IDLE);
    assign o_result.valid            = r_out_valid;
    assign o_result.kind             = r_kind;
    assign o_result.data_byte        = r_data;
    assign o_result.first_of_message = r_first;
    assign o_result.last_of_message  = r_lastm;
    assign o_result.last_of_run      = r_lastr;

endmodule

[sv/isotp_checker.sv]
module isotp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_kind,
    input logic [7:0] i_data_byte,
    input logic       i_first,
    input logic       i_lastm,
    input logic       i_lastr
);

    // no result pending after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

    // a flow-control request carries no message byte and ends its frame
    a_fc_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == isotp_pkg::KIND_FC) |->
            (i_data_byte == 8'h00 && !i_first && !i_lastm && i_lastr))
        else $error("malformed flow-control request");

    // while a frame is still being unloaded no new frame is taken
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_lastr) |-> !i_in_ready)
        else $error("frame input ready in the middle of a run");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_kind) && $stable(i_data_byte) &&
             $stable(i_first) && $stable(i_lastm) && $stable(i_lastr)))
        else $error("stalled result changed");

endmodule

bind isotp_receive_reassembler_unit isotp_checker u_isotp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_frame.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_kind      (o_result.kind),
    .i_data_byte (o_result.data_byte),
    .i_first     (o_result.first_of_message),
    .i_lastm     (o_result.last_of_message),
    .i_lastr     (o_result.last_of_run)
);

[tb/tb_top.sv]
module tb_top;

    localparam logic [3:0] TYPE_FLOW  = 4'h3;
    localparam int         N_ITEMS    = 280;
    localparam int         QUIET_MAX  = 1000;
    localparam int         DRAIN_WAIT = 20;
    localparam int         MAX_SHOWN  = 10;

    // one CAN payload, index 0 is byte0
    typedef logic [7:0][isotp_pkg::BYTE_W-1:0] t_frame;

    typedef struct packed {
        logic                         kind;
        logic [isotp_pkg::BYTE_W-1:0] data_byte;
        logic                         first_of_message;
        logic                         last_of_message;
        logic                         last_of_run;
    } t_result;

    // receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_THIRD,
        STALL_RUNS
    } t_stall_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    isotp_frame_if  frame_ch ();
    isotp_result_if result_ch ();

    isotp_receive_reassembler_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch)
    );

    t_frame            frames_to_send[$];
    t_result           pending_results[$];
    t_frame            on_bus;
    int                n_items;
    int                n_errors;
    int                quiet_cycles;

    // reassembly state of the predictor
    logic                        rx_active;
    logic [isotp_pkg::LEN_W-1:0] rx_len;
    logic [isotp_pkg::LEN_W-1:0] rx_count;

    // clock
    always #5 i_clk = ~i_clk;

    // payload with random bytes 2..7
    function automatic t_frame frame_of(logic [3:0] ftype, logic [3:0] low, logic [7:0] b1);
        t_frame f;
        f[0] = {ftype, low};
        f[1] = b1;
        for (int i = 2; i < 8; i++)
            f[i] = 8'($urandom_range(0, 255));
        return f;
    endfunction

    function automatic t_frame with_fill(t_frame f, logic [7:0] v);
        for (int i = 1; i < 8; i++)
            f[i] = v;
        return f;
    endfunction

    function automatic void add_frame(t_frame f, bit counted);
        frames_to_send.push_back(f);
        if (counted)
            n_items++;
    endfunction

    // expected results of one accepted frame, updates reassembly state
    function automatic void reassemble_frame(t_frame f);
        logic [3:0] ftype;
        logic [3:0] low;
        int         base;
        int         avail;
        int         start;
        int         take;
        bit         done;
        t_result    r;
        ftype = f[0][7:4];
        low   = f[0][3:0];
        if (ftype == isotp_pkg::TYPE_SINGLE) begin
            if (low != 0 && low <= isotp_pkg::MAX_BYTES) begin
                for (int j = 0; j < low; j++) begin
                    r.kind             = isotp_pkg::KIND_DATA;
                    r.data_byte        = f[1 + j];
                    r.first_of_message = (j == 0);
                    r.last_of_message  = (j == low - 1);
                    r.last_of_run      = (j == low - 1);
                    pending_results.push_back(r);
                end
            end
        end else if (ftype == isotp_pkg::TYPE_FIRST ||
                     (ftype == isotp_pkg::TYPE_CONSEC && rx_active)) begin
            if (ftype == isotp_pkg::TYPE_FIRST) begin
                rx_active = 1'b1;
                rx_len    = {low, f[1]};
                rx_count  = '0;
                base      = 2;
                avail     = 6;
            end else begin
                base  = 1;
                avail = 7;
            end
            start = int'(rx_count);
            // clip to what remains of the message
            if (start + avail > int'(rx_len))
                take = int'(rx_len) - start;
            else
                take = avail;
            done = (start + take == int'(rx_len));
            for (int j = 0; j < take; j++) begin
                r.kind             = isotp_pkg::KIND_DATA;
                r.data_byte        = f[base + j];
                r.first_of_message = (start == 0 && j == 0);
                r.last_of_message  = (done && j == take - 1);
                r.last_of_run      = (ftype == isotp_pkg::TYPE_CONSEC && j == take - 1);
                pending_results.push_back(r);
            end
            rx_count = isotp_pkg::LEN_W'(start + take);
            if (done) begin
                rx_active = 1'b0;
                rx_count  = '0;
            end
            // first frame always ends with the flow-control request
            if (ftype == isotp_pkg::TYPE_FIRST) begin
                r = '{kind: isotp_pkg::KIND_FC, data_byte: 8'h00, first_of_message: 1'b0,
                      last_of_message: 1'b0, last_of_run: 1'b1};
                pending_results.push_back(r);
            end
        end
    endfunction

    // directed frames: extremes and corner cases
    task automatic build_directed();
        add_frame(with_fill(frame_of(isotp_pkg::TYPE_SINGLE, 4'd1, 8'h00), 8'h00), 1);
        add_frame(with_fill(frame_of(isotp_pkg::TYPE_SINGLE, 4'd7, 8'hFF), 8'hFF), 1);
        add_frame(frame_of(isotp_pkg::TYPE_SINGLE, 4'd0, 8'h5A), 0);
        add_frame(frame_of(isotp_pkg::TYPE_SINGLE, 4'd8, 8'hA5), 0);
        add_frame(with_fill(frame_of(isotp_pkg::TYPE_SINGLE, 4'hF, 8'hFF), 8'hFF), 0);
        add_frame(frame_of(isotp_pkg::TYPE_CONSEC, 4'd1, 8'h11), 0);
        // zero length, short and exact first frames
        add_frame(frame_of(isotp_pkg::TYPE_FIRST, 4'd0, 8'd0), 1);
        add_frame(frame_of(isotp_pkg::TYPE_FIRST, 4'd0, 8'd3), 1);
        add_frame(frame_of(isotp_pkg::TYPE_FIRST, 4'd0, 8'd6), 1);
        // exact fit over two consecutive frames
        add_frame(frame_of(isotp_pkg::TYPE_FIRST, 4'd0, 8'd20), 1);
        add_frame(frame_of(isotp_pkg::TYPE_CONSEC, 4'd1, 8'h00), 1);
        add_frame(frame_of(isotp_pkg::TYPE_CONSEC, 4'd2, 8'hFF), 1);
        // overrun in the final consecutive frame, then one when idle
        add_frame(frame_of(isotp_pkg::TYPE_FIRST, 4'd0, 8'd15), 1);
        add_frame(frame_of(isotp_pkg::TYPE_CONSEC, 4'd1, 8'h21), 1);
        add_frame(frame_of(isotp_pkg::TYPE_CONSEC, 4'd2, 8'h22), 1);
        add_frame(frame_of(isotp_pkg::TYPE_CONSEC, 4'd3, 8'h23), 0);
        // longest message, single frame inside, then restart by a new first frame
        add_frame(with_fill(frame_of(isotp_pkg::TYPE_FIRST, 4'hF, 8'hFF), 8'hFF), 1);
        add_frame(frame_of(isotp_pkg::TYPE_CONSEC, 4'd1, 8'h31), 1);
        add_frame(frame_of(isotp_pkg::TYPE_SINGLE, 4'd2, 8'h41), 1);
        add_frame(frame_of(isotp_pkg::TYPE_CONSEC, 4'd2, 8'h32), 1);
        add_frame(frame_of(isotp_pkg::TYPE_FIRST, 4'd0, 8'd8), 1);
        add_frame(frame_of(isotp_pkg::TYPE_CONSEC, 4'd1, 8'h51), 1);
        // flow control and unknown types
        add_frame(frame_of(TYPE_FLOW, 4'd0, 8'h00), 0);
        add_frame(with_fill(frame_of(4'hF, 4'hF, 8'hFF), 8'hFF), 0);
        add_frame(with_fill(frame_of(4'h4, 4'h0, 8'h00), 8'h00), 0);
    endtask

    // random traffic, mostly well-formed messages
    task automatic build_random();
        int pick;
        int msg_len;
        int n_cf;
        logic [3:0] low;
        while (n_items < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                if ($urandom_range(0, 9) == 0) begin
                    low = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(8, 15));
                    add_frame(frame_of(isotp_pkg::TYPE_SINGLE, low, 8'($urandom)), 0);
                end else begin
                    add_frame(frame_of(isotp_pkg::TYPE_SINGLE, 4'($urandom_range(1, 7)),
                                       8'($urandom)), 1);
                end
            end else if (pick < 85) begin
                if ($urandom_range(0, 9) == 0)
                    msg_len = $urandom_range(0, 4095);
                else
                    msg_len = $urandom_range(0, 60);
                add_frame(frame_of(isotp_pkg::TYPE_FIRST, 4'(msg_len >> 8), 8'(msg_len)), 1);
                n_cf = (msg_len > 6) ? (msg_len - 6 + 6) / 7 : 0;
                // long messages are abandoned after a few frames
                if (n_cf > 10)
                    n_cf = $urandom_range(1, 4);
                else if ($urandom_range(0, 9) == 0)
                    n_cf = $urandom_range(0, n_cf);
                else if ($urandom_range(0, 9) == 0)
                    n_cf++;
                for (int i = 0; i < n_cf; i++) begin
                    if ($urandom_range(0, 19) == 0)
                        add_frame(frame_of(isotp_pkg::TYPE_SINGLE, 4'($urandom_range(1, 7)),
                                           8'($urandom)), 1);
                    low = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'(i + 1);
                    add_frame(frame_of(isotp_pkg::TYPE_CONSEC, low, 8'($urandom)), 1);
                end
            end else begin
                add_frame(frame_of(4'($urandom), 4'($urandom), 8'($urandom)), 0);
            end
        end
    endtask

    // frame sender: bursts with random gaps
    int gap_left;
    int burst_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_ch.valid <= 1'b0;
            gap_left       <= 0;
            burst_left     <= 0;
        end else begin
            if (frame_ch.valid && frame_ch.ready)
                reassemble_frame(on_bus);
            if (!frame_ch.valid || frame_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left       <= gap_left - 1;
                    frame_ch.valid <= 1'b0;
                end else if (frames_to_send.size() != 0) begin
                    on_bus = frames_to_send.pop_front();
                    frame_ch.byte0 <= on_bus[0];
                    frame_ch.byte1 <= on_bus[1];
                    frame_ch.byte2 <= on_bus[2];
                    frame_ch.byte3 <= on_bus[3];
                    frame_ch.byte4 <= on_bus[4];
                    frame_ch.byte5 <= on_bus[5];
                    frame_ch.byte6 <= on_bus[6];
                    frame_ch.byte7 <= on_bus[7];
                    frame_ch.valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        gap_left   <= $urandom_range(1, 6);
                        burst_left <= ($urandom_range(0, 3) == 0) ?
                                      $urandom_range(20, 40) : $urandom_range(1, 8);
                    end
                end else begin
                    frame_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: stall pattern is drawn anew each time the 6-bit mode_cycle counter wraps
    t_stall_mode stall_mode;
    logic [5:0]  mode_cycle;
    int          stall_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            stall_mode      <= STALL_NONE;
            mode_cycle      <= '0;
            stall_left      <= 0;
        end else begin
            mode_cycle <= mode_cycle + 1'b1;
            if (mode_cycle == '1)
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
            case (stall_mode)
                STALL_NONE: begin
                    result_ch.ready <= 1'b1;
                end
                STALL_COIN: begin
                    result_ch.ready <= ($urandom_range(0, 1) == 1);
                end
                STALL_THIRD: begin
                    result_ch.ready <= (mode_cycle % 3 == 0);
                end
                default: begin
                    if (stall_left != 0) begin
                        stall_left      <= stall_left - 1;
                        result_ch.ready <= 1'b0;
                    end else begin
                        result_ch.ready <= 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            stall_left <= $urandom_range(1, 8);
                    end
                end
            endcase
        end
    end

    // result checker against the oldest expectation
    t_result got;
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = '{kind: result_ch.kind, data_byte: result_ch.data_byte,
                    first_of_message: result_ch.first_of_message,
                    last_of_message: result_ch.last_of_message,
                    last_of_run: result_ch.last_of_run};
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("unexpected result: kind=%0b data=%02h first=%0b",
                             got.kind, got.data_byte, got.first_of_message,
                             " last=%0b run_end=%0b",
                             got.last_of_message, got.last_of_run);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                    got.first_of_message !== want.first_of_message ||
                    got.last_of_message !== want.last_of_message ||
                    got.last_of_run !== want.last_of_run) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("result differs: expected kind=%0b data=%02h first=%0b",
                                 want.kind, want.data_byte, want.first_of_message,
                                 " last=%0b run_end=%0b,",
                                 want.last_of_message, want.last_of_run,
                                 " got kind=%0b data=%02h first=%0b",
                                 got.kind, got.data_byte, got.first_of_message,
                                 " last=%0b run_end=%0b",
                                 got.last_of_message, got.last_of_run);
                end
            end
        end
    end

    // cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_MAX)
            @(posedge i_clk);
        $display("isotp_receive_reassembler_unit: mismatch");
        $finish;
    end

    // reset, stimulus and end of run
    initial begin
        i_rst_n         = 1'b0;
        frame_ch.valid  = 1'b0;
        frame_ch.byte0  = '0;
        frame_ch.byte1  = '0;
        frame_ch.byte2  = '0;
        frame_ch.byte3  = '0;
        frame_ch.byte4  = '0;
        frame_ch.byte5  = '0;
        frame_ch.byte6  = '0;
        frame_ch.byte7  = '0;
        result_ch.ready = 1'b0;
        quiet_cycles    = 0;
        n_items         = 0;
        n_errors        = 0;
        rx_active       = 1'b0;
        rx_len          = '0;
        rx_count        = '0;
        build_directed();
        build_random();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (frames_to_send.size() != 0 || frame_ch.valid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("isotp_receive_reassembler_unit: match");
        end else begin
            $display("isotp_receive_reassembler_unit: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
sv/isotp_pkg.sv
sv/isotp_frame_if.sv
sv/isotp_result_if.sv
sv/isotp_len_unit.sv
sv/isotp_receive_reassembler_unit.sv
sv/isotp_checker.sv
tb/tb_top.sv
